// ===== design/dma_channel_register_file_assert.svh =====
// Assertion macros used by the DMA channel register file top level.
`ifndef DMA_CHANNEL_REGISTER_FILE_ASSERT_SVH
`define DMA_CHANNEL_REGISTER_FILE_ASSERT_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define DMACRF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define DMACRF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DMACRF_ASSERT(label, prop, msg)
`define DMACRF_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== design/dmacrf_pkg.sv =====
// Shared types and port constants for the DMA channel register file.
`timescale 1ns / 1ps
package dmacrf_pkg;

  // Register kind that a port decodes to
  typedef enum logic [3:0] {
    K_NONE,
    K_ADDR,
    K_COUNT,
    K_PAGE,
    K_SMASK,
    K_MODE,
    K_FFRST,
    K_MCLR,
    K_UNMASK,
    K_MMASK
  } kind_t;

  // Decoded access: kind, controller and channel
  typedef struct packed {
    kind_t      kind;
    logic       ctl;
    logic [2:0] ch;
  } dec_t;

  localparam int NUM_CH = 8;

  // Page register ports, indexed by channel
  localparam logic [7:0] PAGE_PORTS [NUM_CH] = '{
    8'h87, 8'h83, 8'h81, 8'h82, 8'h8f, 8'h8b, 8'h89, 8'h8a
  };

  // Controller 0 control ports
  localparam logic [7:0] SMASK_PORT0  = 8'h0a;
  localparam logic [7:0] MODE_PORT0   = 8'h0b;
  localparam logic [7:0] FFRST_PORT0  = 8'h0c;
  localparam logic [7:0] MCLR_PORT0   = 8'h0d;
  localparam logic [7:0] UNMASK_PORT0 = 8'h0e;
  localparam logic [7:0] MMASK_PORT0  = 8'h0f;

  // Controller 1 control ports
  localparam logic [7:0] SMASK_PORT1  = 8'hd4;
  localparam logic [7:0] MODE_PORT1   = 8'hd6;
  localparam logic [7:0] FFRST_PORT1  = 8'hd8;
  localparam logic [7:0] MCLR_PORT1   = 8'hda;
  localparam logic [7:0] UNMASK_PORT1 = 8'hdc;
  localparam logic [7:0] MMASK_PORT1  = 8'hde;

  // Controller 0 address/count ports span 0x00..0x07, controller 1 the even ports 0xc0..0xce
  localparam logic [7:0] CTL0_LAST_PORT = 8'h07;
  localparam logic [3:0] CTL1_PORT_HI   = 4'hc;

endpackage

// ===== design/dmacrf_decode.sv =====
// Port address decoder: maps an I/O port to register kind, controller and channel.
`timescale 1ns / 1ps
module dmacrf_decode import dmacrf_pkg::*; (
  input  logic [7:0] port,
  output dec_t       dec
);

  logic       page_hit;
  logic [2:0] page_ch;

  // Page register lookup
  always_comb begin
    page_hit = 1'b0;
    page_ch  = 3'd0;
    for (int i = 0; i < NUM_CH; i++) begin
      if (port == PAGE_PORTS[i]) begin
        page_hit = 1'b1;
        page_ch  = 3'(i);
      end
    end
  end

  // Kind, controller and channel
  always_comb begin
    dec.kind = K_NONE;
    dec.ctl  = 1'b0;
    dec.ch   = 3'd0;
    if (port <= CTL0_LAST_PORT) begin
      dec.kind = port[0] ? K_COUNT : K_ADDR;
      dec.ch   = {1'b0, port[2:1]};
    end else if (port[7:4] == CTL1_PORT_HI && !port[0]) begin
      dec.kind = port[1] ? K_COUNT : K_ADDR;
      dec.ctl  = 1'b1;
      dec.ch   = {1'b1, port[3:2]};
    end else if (page_hit) begin
      dec.kind = K_PAGE;
      dec.ctl  = page_ch[2];
      dec.ch   = page_ch;
    end else begin
      case (port)
        SMASK_PORT0:  dec.kind = K_SMASK;
        MODE_PORT0:   dec.kind = K_MODE;
        FFRST_PORT0:  dec.kind = K_FFRST;
        MCLR_PORT0:   dec.kind = K_MCLR;
        UNMASK_PORT0: dec.kind = K_UNMASK;
        MMASK_PORT0:  dec.kind = K_MMASK;
        SMASK_PORT1: begin
          dec.kind = K_SMASK;
          dec.ctl  = 1'b1;
        end
        MODE_PORT1: begin
          dec.kind = K_MODE;
          dec.ctl  = 1'b1;
        end
        FFRST_PORT1: begin
          dec.kind = K_FFRST;
          dec.ctl  = 1'b1;
        end
        MCLR_PORT1: begin
          dec.kind = K_MCLR;
          dec.ctl  = 1'b1;
        end
        UNMASK_PORT1: begin
          dec.kind = K_UNMASK;
          dec.ctl  = 1'b1;
        end
        MMASK_PORT1: begin
          dec.kind = K_MMASK;
          dec.ctl  = 1'b1;
        end
        default: dec.kind = K_NONE;
      endcase
      dec.ch = {dec.ctl, 2'b00};
    end
  end

endmodule

// ===== design/dma_channel_register_file.sv =====
// Top level of the two-controller, eight-channel DMA register file.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one byte port access per
//   transfer: req_type (0 read, 1 write), port and wdata. Output channel
//   (out_valid / out_stall) returns one result per access: rdata (0 on
//   writes and on reads of control ports and unmodelled ports) and port_hit.
//   Path: an access is held in the input register, where the port is
//   decoded and the channel registers are read and updated. As it moves
//   on, its result is registered in the result register and waits there
//   until the receiver takes it. Throughput: one access per cycle unless
//   the receiver stalls; the single decode/update pass between the input
//   and result registers sets this figure.
//   Reset (rst, synchronous): all address, count, page and mode registers
//   clear, every channel is masked and both byte-pointer flip-flops point
//   at the low byte. Both pipeline registers empty.
//   When the receiver stalls, the held result stays on the output; one
//   more access is taken into the input register and then in_stall rises
//   until the result is taken. Register state changes only as an access
//   moves into the result register, so nothing is lost or repeated.
`timescale 1ns / 1ps
`include "dma_channel_register_file_assert.svh"
module dma_channel_register_file import dmacrf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       req_type,
  input  logic [7:0] port,
  input  logic [7:0] wdata,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] rdata,
  output logic       port_hit
);

  // Input register
  logic       s1_valid;
  logic       s1_wr;
  logic [7:0] s1_port;
  logic [7:0] s1_wdata;

  // Channel state
  logic [15:0] base_address [NUM_CH];
  logic [15:0] word_count   [NUM_CH];
  logic [7:0]  page_byte    [NUM_CH];
  logic [5:0]  mode_bits    [NUM_CH];
  logic [NUM_CH-1:0] channel_masked;
  logic [1:0]  high_byte_next;

  dec_t        dec;
  logic        advance;
  logic        in_take;
  logic        cur_ptr;
  logic [2:0]  sel_idx;
  logic [15:0] sel_word;
  logic [7:0]  rdata_next;
  logic        port_hit_next;

  dmacrf_decode u_decode (
    .port (s1_port),
    .dec  (dec)
  );

  // Handshake: input register moves on when the result register is empty or being taken
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_wr    <= req_type;
      s1_port  <= port;
      s1_wdata <= wdata;
    end
  end

  // Read path: byte pointer selects low or high half
  assign cur_ptr  = high_byte_next[dec.ctl];
  assign sel_idx  = {dec.ctl, s1_wdata[1:0]};
  assign sel_word = (dec.kind == K_ADDR) ? base_address[dec.ch] : word_count[dec.ch];

  always_comb begin
    rdata_next = 8'd0;
    if (!s1_wr) begin
      case (dec.kind)
        K_ADDR, K_COUNT: rdata_next = cur_ptr ? sel_word[15:8] : sel_word[7:0];
        K_PAGE:          rdata_next = page_byte[dec.ch];
        default:         rdata_next = 8'd0;
      endcase
    end
  end

  assign port_hit_next = (dec.kind != K_NONE);

  // Channel state update as the transfer completes its pass
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        base_address[i] <= 16'd0;
        word_count[i]   <= 16'd0;
        page_byte[i]    <= 8'd0;
        mode_bits[i]    <= 6'd0;
      end
      channel_masked <= '1;
      high_byte_next <= 2'b00;
    end else if (advance) begin
      case (dec.kind)
        K_ADDR: begin
          if (s1_wr) begin
            if (cur_ptr) base_address[dec.ch][15:8] <= s1_wdata;
            else         base_address[dec.ch][7:0]  <= s1_wdata;
          end
          high_byte_next[dec.ctl] <= !cur_ptr;
        end
        K_COUNT: begin
          if (s1_wr) begin
            if (cur_ptr) word_count[dec.ch][15:8] <= s1_wdata;
            else         word_count[dec.ch][7:0]  <= s1_wdata;
          end
          high_byte_next[dec.ctl] <= !cur_ptr;
        end
        K_PAGE: begin
          if (s1_wr) page_byte[dec.ch] <= s1_wdata;
        end
        K_SMASK: begin
          if (s1_wr) channel_masked[sel_idx] <= s1_wdata[2];
        end
        K_MODE: begin
          if (s1_wr) mode_bits[sel_idx] <= s1_wdata[7:2];
        end
        K_FFRST: begin
          if (s1_wr) high_byte_next[dec.ctl] <= 1'b0;
        end
        K_MCLR: begin
          if (s1_wr) begin
            if (dec.ctl) channel_masked[7:4] <= 4'hf;
            else         channel_masked[3:0] <= 4'hf;
            high_byte_next[dec.ctl] <= 1'b0;
          end
        end
        K_UNMASK: begin
          if (s1_wr) begin
            if (dec.ctl) channel_masked[7:4] <= 4'h0;
            else         channel_masked[3:0] <= 4'h0;
          end
        end
        K_MMASK: begin
          if (s1_wr) begin
            if (dec.ctl) channel_masked[7:4] <= s1_wdata[3:0];
            else         channel_masked[3:0] <= s1_wdata[3:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rdata    <= rdata_next;
      port_hit <= port_hit_next;
    end
  end

  // Checks
  `DMACRF_ASSERT_ALWAYS(a_reset_empty,
    rst |=> (!out_valid && !s1_valid),
    "pipeline not empty after reset")
  `DMACRF_ASSERT(a_write_reads_zero,
    (advance && s1_wr) |=> (out_valid && rdata == 8'd0),
    "write transfer returned nonzero data")
  `DMACRF_ASSERT(a_ptr_toggle,
    (advance && (dec.kind == K_ADDR || dec.kind == K_COUNT))
      |=> (high_byte_next[$past(dec.ctl)] != $past(cur_ptr)),
    "byte pointer did not toggle")
  `DMACRF_ASSERT(a_mclr0,
    (advance && s1_wr && dec.kind == K_MCLR && !dec.ctl)
      |=> (channel_masked[3:0] == 4'hf && !high_byte_next[0]),
    "master clear on controller 0 incomplete")
  `DMACRF_ASSERT(a_mode_write,
    (advance && s1_wr && dec.kind == K_MODE)
      |=> (mode_bits[$past(sel_idx)] == $past(s1_wdata[7:2])),
    "mode bits not stored")

endmodule
